// File: design/tcs_pkg.sv
package tcs_pkg;

	localparam int COORD_BITS = 12;
	localparam int NUM_BITS = 2 * COORD_BITS + 3;
	localparam int LANES = 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t first_x;
		coord_t first_y;
		coord_t second_x;
		coord_t second_y;
		coord_t third_x;
		coord_t third_y;
		coord_t column;
	} in_t;

	typedef struct packed {
		coord_t                  span_start;
		logic [COORD_BITS-1:0]   span_length;
	} out_t;

	// one edge on its way into the divider: |numerator|, divisor and sideband
	typedef struct packed {
		logic [NUM_BITS-1:0]     mag;
		logic [COORD_BITS-1:0]   dx;
		logic                    neg;
		logic                    zw;
		coord_t                  ys;
	} edge_req_t;

	typedef struct packed {
		edge_req_t [LANES-1:0]   lane;
		logic                    outside;
	} div_req_t;

	typedef struct packed {
		logic [COORD_BITS-1:0]   quo;
		logic                    neg;
		logic                    zw;
		coord_t                  ys;
	} edge_res_t;

	typedef struct packed {
		edge_res_t [LANES-1:0]   lane;
		logic                    outside;
	} div_res_t;

endpackage

// File: design/tcs_setup.sv
module tcs_setup (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	output logic              in_rdy,
	input  tcs_pkg::in_t      in_data,
	output logic              out_vld,
	input  logic              out_rdy,
	output tcs_pkg::div_req_t out_data
);
	import tcs_pkg::*;

	localparam int DW  = COORD_BITS + 1;
	localparam int PW1 = 2 * COORD_BITS + 1;
	localparam int PW2 = 2 * COORD_BITS + 2;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} vtx_t;

	typedef logic signed [DW-1:0] diff_t;

	logic [4:1] adv;
	logic       vld_s1, vld_s2, vld_s3, vld_s4;

	// stage 1: stable sort by x
	vtx_t   v0, v1, v2, tmp;
	vtx_t   a_s1, b_s1, c_s1;
	coord_t col_s1;

	// stage 2: edge selection
	coord_t xs [LANES];
	coord_t ys [LANES];
	coord_t xe [LANES];
	coord_t ye [LANES];
	diff_t  dx_c [LANES];
	diff_t  dx_s2 [LANES];
	diff_t  dy_s2 [LANES];
	diff_t  t_s2 [LANES];
	coord_t ys_s2 [LANES];
	logic   zw_s2 [LANES];
	logic   outside_s2;

	// stage 3: products
	logic signed [PW1-1:0]  p1_s3 [LANES];
	logic signed [PW2-1:0]  p2_s3 [LANES];
	logic [COORD_BITS-1:0]  dx_s3 [LANES];
	coord_t                 ys_s3 [LANES];
	logic                   zw_s3 [LANES];
	logic                   outside_s3;

	// stage 4: numerator magnitude
	logic signed [NUM_BITS-1:0] num [LANES];
	div_req_t                   req_s4;

	assign adv[4] = !vld_s4 || out_rdy;
	assign adv[3] = !vld_s3 || adv[4];
	assign adv[2] = !vld_s2 || adv[3];
	assign adv[1] = !vld_s1 || adv[2];
	assign in_rdy = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv[1]) vld_s1 <= in_vld;
			if (adv[2]) vld_s2 <= vld_s1;
			if (adv[3]) vld_s3 <= vld_s2;
			if (adv[4]) vld_s4 <= vld_s3;
		end
	end

	always_comb begin
		tmp = '0;
		v0 = '{x: in_data.first_x, y: in_data.first_y};
		v1 = '{x: in_data.second_x, y: in_data.second_y};
		v2 = '{x: in_data.third_x, y: in_data.third_y};
		if ($signed(v0.x) > $signed(v1.x)) begin
			tmp = v0;
			v0 = v1;
			v1 = tmp;
		end
		if ($signed(v1.x) > $signed(v2.x)) begin
			tmp = v1;
			v1 = v2;
			v2 = tmp;
		end
		if ($signed(v0.x) > $signed(v1.x)) begin
			tmp = v0;
			v0 = v1;
			v1 = tmp;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1] && in_vld) begin
			a_s1   <= v0;
			b_s1   <= v1;
			c_s1   <= v2;
			col_s1 <= in_data.column;
		end
	end

	// lane 0 is edge AC, lane 1 is AB before B and BC from B on
	always_comb begin
		xs[0] = a_s1.x;
		ys[0] = a_s1.y;
		xe[0] = c_s1.x;
		ye[0] = c_s1.y;
		if ($signed(col_s1) < $signed(b_s1.x)) begin
			xs[1] = a_s1.x;
			ys[1] = a_s1.y;
			xe[1] = b_s1.x;
			ye[1] = b_s1.y;
		end else begin
			xs[1] = b_s1.x;
			ys[1] = b_s1.y;
			xe[1] = c_s1.x;
			ye[1] = c_s1.y;
		end
		for (int l = 0; l < LANES; l++) begin
			dx_c[l] = DW'($signed(xe[l])) - DW'($signed(xs[l]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2] && vld_s1) begin
			for (int l = 0; l < LANES; l++) begin
				dx_s2[l] <= dx_c[l];
				dy_s2[l] <= DW'($signed(ye[l])) - DW'($signed(ys[l]));
				t_s2[l]  <= DW'($signed(col_s1)) - DW'($signed(xs[l]));
				ys_s2[l] <= ys[l];
				zw_s2[l] <= dx_c[l][DW-1] || (dx_c[l] == '0);
			end
			outside_s2 <= ($signed(col_s1) < $signed(a_s1.x)) ||
				($signed(col_s1) > $signed(c_s1.x));
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3] && vld_s2) begin
			for (int l = 0; l < LANES; l++) begin
				p1_s3[l] <= PW1'(ys_s2[l]) * PW1'(dx_s2[l]);
				p2_s3[l] <= PW2'(dy_s2[l]) * PW2'(t_s2[l]);
				dx_s3[l] <= zw_s2[l] ? COORD_BITS'(1) : dx_s2[l][COORD_BITS-1:0];
				ys_s3[l] <= ys_s2[l];
				zw_s3[l] <= zw_s2[l];
			end
			outside_s3 <= outside_s2;
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			num[l] = NUM_BITS'(p1_s3[l]) + NUM_BITS'(p2_s3[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4] && vld_s3) begin
			for (int l = 0; l < LANES; l++) begin
				req_s4.lane[l].mag <= num[l][NUM_BITS-1] ? NUM_BITS'(-num[l])
					: NUM_BITS'(num[l]);
				req_s4.lane[l].neg <= num[l][NUM_BITS-1];
				req_s4.lane[l].dx  <= dx_s3[l];
				req_s4.lane[l].zw  <= zw_s3[l];
				req_s4.lane[l].ys  <= ys_s3[l];
			end
			req_s4.outside <= outside_s3;
		end
	end

	assign out_vld  = vld_s4;
	assign out_data = req_s4;

endmodule

// File: design/tcs_div.sv
module tcs_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	output logic              in_rdy,
	input  tcs_pkg::div_req_t in_data,
	output logic              out_vld,
	input  logic              out_rdy,
	output tcs_pkg::div_res_t out_data
);
	import tcs_pkg::*;

	localparam int STAGES = COORD_BITS;

	logic [STAGES:0]        adv;
	logic [STAGES-1:0]      vld_s;
	logic [STAGES-1:0]      vin;
	edge_req_t              lane_s [STAGES][LANES];
	edge_req_t              lane_in [STAGES][LANES];
	logic [COORD_BITS-1:0]  quo_s [STAGES][LANES];
	logic [COORD_BITS-1:0]  quo_in [STAGES][LANES];
	logic [STAGES-1:0]      outside_s;
	logic [STAGES-1:0]      outside_in;

	assign adv[STAGES] = out_rdy;
	assign in_rdy      = adv[0];

	genvar i, l;
	for (i = 0; i < STAGES; i++) begin : g_stage
		localparam int K = STAGES - 1 - i;

		assign adv[i] = !vld_s[i] || adv[i+1];

		if (i == 0) begin : g_head
			assign vin[i]        = in_vld;
			assign outside_in[i] = in_data.outside;
			for (l = 0; l < LANES; l++) begin : g_src
				assign lane_in[i][l] = in_data.lane[l];
				assign quo_in[i][l]  = '0;
			end
		end else begin : g_body
			assign vin[i]        = vld_s[i-1];
			assign outside_in[i] = outside_s[i-1];
			for (l = 0; l < LANES; l++) begin : g_src
				assign lane_in[i][l] = lane_s[i-1][l];
				assign quo_in[i][l]  = quo_s[i-1][l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv[i]) begin
				vld_s[i] <= vin[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[i] && vin[i]) begin
				outside_s[i] <= outside_in[i];
			end
		end

		for (l = 0; l < LANES; l++) begin : g_lane
			logic [NUM_BITS-1:0] trial;
			logic                take;

			assign trial = NUM_BITS'(lane_in[i][l].dx) << K;
			assign take  = lane_in[i][l].mag >= trial;

			always_ff @(posedge clk) begin
				if (adv[i] && vin[i]) begin
					lane_s[i][l].mag <= take ? lane_in[i][l].mag - trial
						: lane_in[i][l].mag;
					lane_s[i][l].dx  <= lane_in[i][l].dx;
					lane_s[i][l].neg <= lane_in[i][l].neg;
					lane_s[i][l].zw  <= lane_in[i][l].zw;
					lane_s[i][l].ys  <= lane_in[i][l].ys;
					quo_s[i][l]      <= {quo_in[i][l][COORD_BITS-2:0], take};
				end
			end

			assign out_data.lane[l].quo = quo_s[STAGES-1][l];
			assign out_data.lane[l].neg = lane_s[STAGES-1][l].neg;
			assign out_data.lane[l].zw  = lane_s[STAGES-1][l].zw;
			assign out_data.lane[l].ys  = lane_s[STAGES-1][l].ys;
		end
	end

	assign out_data.outside = outside_s[STAGES-1];
	assign out_vld          = vld_s[STAGES-1];

endmodule

// File: design/tcs_span.sv
module tcs_span (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	output logic              in_rdy,
	input  tcs_pkg::div_res_t in_data,
	output logic              out_vld,
	input  logic              out_rdy,
	output tcs_pkg::out_t     out_data
);
	import tcs_pkg::*;

	localparam int EW = COORD_BITS + 1;

	logic signed [EW-1:0] ev [LANES];
	logic signed [EW-1:0] mag;
	logic signed [EW-1:0] lo;
	logic signed [EW:0]   gap;
	logic                 vld_q;
	out_t                 span_q;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			mag = $signed({1'b0, in_data.lane[l].quo});
			if (in_data.lane[l].zw) begin
				ev[l] = EW'(in_data.lane[l].ys);
			end else if (in_data.lane[l].neg) begin
				ev[l] = -mag;
			end else begin
				ev[l] = mag;
			end
		end
		lo  = (ev[0] < ev[1]) ? ev[0] : ev[1];
		gap = (ev[0] < ev[1]) ? (EW+1)'(ev[1]) - (EW+1)'(ev[0])
			: (EW+1)'(ev[0]) - (EW+1)'(ev[1]);
	end

	assign in_rdy = !vld_q || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_rdy) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			if (in_data.outside) begin
				span_q <= '0;
			end else begin
				span_q.span_start  <= lo[COORD_BITS-1:0];
				span_q.span_length <= gap[COORD_BITS-1:0];
			end
		end
	end

	assign out_vld  = vld_q;
	assign out_data = span_q;

endmodule

// File: design/triangle_column_span.sv
// triangle_column_span
// Returns the filled y span of one screen column of a triangle.
// query channel: three vertices and a column, one transaction per triangle
//   column; the vertices are sorted by x internally, ties keep input order.
// span channel: span_start (lowest filled y) and span_length (pixels,
//   upper edge excluded); both zero when the column lies outside the
//   triangle's x range.
// Query to span: sort, edge setup, multiply, numerator, then the divider stages
//   that resolve the quotients of both edges MSB first, then the output register.
// Throughput: one transaction per cycle unless a low span_ready has filled
//   the pipeline; the two restoring dividers are fully pipelined, one stage
//   per quotient bit.
// Every stage holds its own valid bit and moves whenever it is empty or the
//   next stage moves, so bubbles collapse and query_ready stays high while
//   the pipeline has a free slot even if span_ready is low.
// When span_ready is low the output holds its transaction unchanged and the
//   pipeline fills up behind it; nothing is dropped or repeated.
// Reset (arst_n low) empties the pipeline; no state survives between items.
module triangle_column_span (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           query_valid,
	output logic           query_ready,
	input  tcs_pkg::in_t   query,
	output logic           span_valid,
	input  logic           span_ready,
	output tcs_pkg::out_t  span
);
	import tcs_pkg::*;

	logic     req_vld, req_rdy;
	div_req_t req;
	logic     res_vld, res_rdy;
	div_res_t res;

	tcs_setup u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (query_valid),
		.in_rdy   (query_ready),
		.in_data  (query),
		.out_vld  (req_vld),
		.out_rdy  (req_rdy),
		.out_data (req)
	);

	tcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (req_vld),
		.in_rdy   (req_rdy),
		.in_data  (req),
		.out_vld  (res_vld),
		.out_rdy  (res_rdy),
		.out_data (res)
	);

	tcs_span u_span (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (res_vld),
		.in_rdy   (res_rdy),
		.in_data  (res),
		.out_vld  (span_valid),
		.out_rdy  (span_ready),
		.out_data (span)
	);

endmodule

// File: design/tcs_checker.sv
module tcs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          query_valid,
	input logic          query_ready,
	input tcs_pkg::in_t  query,
	input logic          span_valid,
	input logic          span_ready,
	input tcs_pkg::out_t span
);
	import tcs_pkg::*;

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !span_valid)
		else $error("span_valid high during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && !span_ready |=> span_valid && $stable(span))
		else $error("stalled span transaction changed");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!span_valid |-> query_ready)
		else $error("query stalled with empty output");

	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		span_ready |-> query_ready)
		else $error("query stalled while output drains");

endmodule

bind triangle_column_span tcs_checker u_tcs_checker (.*);
